/* hw/rtl/dfs_pkg.sv */
// ----------------------------------------------------------------------------
// DLE frame stuffer package
// Shared byte codes, command codes, queue job types and stuffing helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package dfs_pkg;

   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned JOB_SYMS    = 4;

   localparam logic [15:0] LIMIT_RESET = 16'd1024;
   localparam logic [15:0] LIMIT_MIN   = 16'd6;
   localparam logic [16:0] HEAD_ROOM   = 17'd4;

   typedef enum logic [1:0] {
      CMD_START = 2'd0,
      CMD_DATA  = 2'd1,
      CMD_END   = 2'd2
   } cmd_type;

   localparam logic [7:0] B_DLE  = 8'h10;
   localparam logic [7:0] B_STX  = 8'h02;
   localparam logic [7:0] B_ETX  = 8'h03;
   localparam logic [7:0] B_XON  = 8'h11;
   localparam logic [7:0] B_XOFF = 8'h13;
   localparam logic [7:0] B_FS   = 8'h1C;
   localparam logic [7:0] B_LC_S = 8'h73;
   localparam logic [7:0] B_LC_Q = 8'h71;
   localparam logic [7:0] B_BAR  = 8'h7C;

   // One symbol is a byte that is either sent raw or through the stuffing map.
   typedef struct packed {
      logic       stuff;
      logic [7:0] value;
   } sym_type;

   // One queued job: up to four symbols, the index of the final one, and the
   // truncated flag that goes with trailer bytes.
   typedef struct packed {
      sym_type [JOB_SYMS-1:0] syms;
      logic [1:0]             last_sym;
      logic                   trunc;
   } job_type;

   function automatic logic is_special(input logic [7:0] b);
      return (b == B_DLE) || (b == B_XOFF) || (b == B_XON) || (b == B_FS);
   endfunction

   function automatic logic [7:0] escape_code(input logic [7:0] b);
      logic [7:0] code;
      case (b)
         B_XOFF:  code = B_LC_S;
         B_XON:   code = B_LC_Q;
         B_FS:    code = B_BAR;
         default: code = B_DLE;
      endcase
      return code;
   endfunction

endpackage

`default_nettype wire

/* hw/rtl/dfs_req_if.sv */
// ----------------------------------------------------------------------------
// DLE frame stuffer request channel
// Valid/ready channel carrying one command transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface dfs_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] cmd;
   logic [7:0] frame_id;
   logic [7:0] frame_seq;
   logic [7:0] data_byte;

   modport source (output valid, cmd, frame_id, frame_seq, data_byte, input ready);
   modport sink   (input valid, cmd, frame_id, frame_seq, data_byte, output ready);
endinterface

`default_nettype wire

/* hw/rtl/dfs_rsp_if.sv */
// ----------------------------------------------------------------------------
// DLE frame stuffer response channel
// Valid/ready channel carrying one output byte per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface dfs_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       run_last;
   logic       truncated;

   modport source (output valid, out_byte, run_last, truncated, input ready);
   modport sink   (input valid, out_byte, run_last, truncated, output ready);
endinterface

`default_nettype wire

/* hw/rtl/dfs_front.sv */
// ----------------------------------------------------------------------------
// DLE frame stuffer front end
// Accepts commands, tracks frame state and the limit, and queues byte jobs.
// ----------------------------------------------------------------------------
`default_nettype none

module dfs_front (
   input  wire logic             clock,
   input  wire logic             reset,
   dfs_req_if.sink               req_if,
   input  wire logic             csr_wr_en,
   input  wire logic [15:0]      csr_wr_data,
   input  wire logic             queue_full,
   output      logic             push,
   output      dfs_pkg::job_type push_job
);

   logic [15:0] frame_limit_ff, frame_limit_in;
   logic [15:0] out_count_ff, out_count_in;
   logic        in_frame_ff, in_frame_in;
   logic        dropped_ff, dropped_in;

   logic        accept;
   logic [1:0]  id_extra, seq_extra;
   logic [16:0] count_sum;
   logic [16:0] grow;

   assign req_if.ready = !queue_full;
   assign accept       = req_if.valid && req_if.ready;
   assign id_extra     = {1'b0, dfs_pkg::is_special(req_if.frame_id)};
   assign seq_extra    = {1'b0, dfs_pkg::is_special(req_if.frame_seq)};

   always_comb begin
      frame_limit_in = csr_wr_en ? csr_wr_data : frame_limit_ff;
      out_count_in   = out_count_ff;
      in_frame_in    = in_frame_ff;
      dropped_in     = dropped_ff;
      push           = 1'b0;
      push_job       = '0;
      grow           = '0;
      count_sum      = {1'b0, out_count_ff};

      if (accept) begin
         case (req_if.cmd)
            dfs_pkg::CMD_START: begin
               dropped_in = 1'b0;
               if (frame_limit_ff <= dfs_pkg::LIMIT_MIN) begin
                  in_frame_in  = 1'b0;
                  out_count_in = '0;
               end else begin
                  in_frame_in  = 1'b1;
                  out_count_in = 16'd4 + {14'd0, id_extra} + {14'd0, seq_extra};
                  push         = 1'b1;
                  push_job.syms[0]  = '{stuff: 1'b0, value: dfs_pkg::B_DLE};
                  push_job.syms[1]  = '{stuff: 1'b0, value: dfs_pkg::B_STX};
                  push_job.syms[2]  = '{stuff: 1'b1, value: req_if.frame_id};
                  push_job.syms[3]  = '{stuff: 1'b1, value: req_if.frame_seq};
                  push_job.last_sym = 2'd3;
               end
            end
            dfs_pkg::CMD_DATA: begin
               if (in_frame_ff) begin
                  if ({1'b0, out_count_ff} + dfs_pkg::HEAD_ROOM < {1'b0, frame_limit_ff}) begin
                     push = 1'b1;
                     push_job.syms[0]  = '{stuff: 1'b1, value: req_if.data_byte};
                     push_job.last_sym = 2'd0;
                     grow = dfs_pkg::is_special(req_if.data_byte) ? 17'd2 : 17'd1;
                  end else begin
                     dropped_in = 1'b1;
                  end
               end
            end
            dfs_pkg::CMD_END: begin
               if (in_frame_ff) begin
                  push        = 1'b1;
                  in_frame_in = 1'b0;
                  push_job.syms[0]  = '{stuff: 1'b0, value: dfs_pkg::B_DLE};
                  push_job.syms[1]  = '{stuff: 1'b0, value: dfs_pkg::B_ETX};
                  push_job.last_sym = 2'd1;
                  push_job.trunc    = dropped_ff;
                  grow = 17'd2;
               end
            end
            default: begin
            end
         endcase

         // Byte count saturates at the top of its range.
         if (grow != '0) begin
            count_sum    = {1'b0, out_count_ff} + grow;
            out_count_in = count_sum[16] ? 16'hFFFF : count_sum[15:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_limit_ff <= dfs_pkg::LIMIT_RESET;
         out_count_ff   <= '0;
         in_frame_ff    <= 1'b0;
         dropped_ff     <= 1'b0;
      end else begin
         frame_limit_ff <= frame_limit_in;
         out_count_ff   <= out_count_in;
         in_frame_ff    <= in_frame_in;
         dropped_ff     <= dropped_in;
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/dfs_queue.sv */
// ----------------------------------------------------------------------------
// DLE frame stuffer job queue
// Small circular queue of byte jobs between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module dfs_queue #(
   parameter int unsigned DEPTH = dfs_pkg::QUEUE_DEPTH
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire dfs_pkg::job_type push_job,
   input  wire logic             pop,
   output      logic             full,
   output      logic             head_valid,
   output      dfs_pkg::job_type head_job
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   dfs_pkg::job_type       entries_ff [DEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic                   do_push, do_pop;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_job   = entries_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = do_push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/dfs_back.sv */
// ----------------------------------------------------------------------------
// DLE frame stuffer back end
// Expands queued jobs into stuffed bytes, one per cycle while the receiver takes them, into an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module dfs_back (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             head_valid,
   input  wire dfs_pkg::job_type head_job,
   output      logic             pop,
   dfs_rsp_if.source             rsp_if
);

   logic [1:0]       sym_ff, sym_in;
   logic             phase_ff, phase_in;
   logic             valid_ff, valid_in;
   logic [7:0]       byte_ff, byte_in;
   logic             last_ff, last_in;
   logic             trunc_ff, trunc_in;

   dfs_pkg::sym_type cur_sym;
   logic             escaped;
   logic             sym_done;
   logic             advance;

   assign cur_sym  = head_job.syms[sym_ff];
   assign escaped  = cur_sym.stuff && dfs_pkg::is_special(cur_sym.value);
   // An escaped symbol takes two bytes: DLE first, then its code.
   assign sym_done = !escaped || phase_ff;
   assign advance  = head_valid && (!valid_ff || rsp_if.ready);
   assign pop      = advance && sym_done && (sym_ff == head_job.last_sym);

   always_comb begin
      sym_in   = sym_ff;
      phase_in = phase_ff;
      valid_in = valid_ff && !rsp_if.ready;
      byte_in  = byte_ff;
      last_in  = last_ff;
      trunc_in = trunc_ff;
      if (advance) begin
         valid_in = 1'b1;
         trunc_in = head_job.trunc;
         last_in  = pop;
         if (escaped && phase_ff) begin
            byte_in = dfs_pkg::escape_code(cur_sym.value);
         end else if (escaped) begin
            byte_in = dfs_pkg::B_DLE;
         end else begin
            byte_in = cur_sym.value;
         end
         if (sym_done) begin
            phase_in = 1'b0;
            sym_in   = pop ? 2'd0 : sym_ff + 2'd1;
         end else begin
            phase_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sym_ff   <= '0;
         phase_ff <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         sym_ff   <= sym_in;
         phase_ff <= phase_in;
         valid_ff <= valid_in;
      end
      byte_ff  <= byte_in;
      last_ff  <= last_in;
      trunc_ff <= trunc_in;
   end

   assign rsp_if.valid     = valid_ff;
   assign rsp_if.out_byte  = byte_ff;
   assign rsp_if.run_last  = last_ff;
   assign rsp_if.truncated = trunc_ff;

endmodule

`default_nettype wire

/* hw/rtl/dle_frame_stuffer_unit.sv */
// ----------------------------------------------------------------------------
// DLE frame stuffer unit
// Builds DLE-STX/DLE-ETX framed byte streams with transparency stuffing.
// ----------------------------------------------------------------------------
// Usage:
// Commands arrive on req_if (start with id and sequence, data byte, end) and
// each output byte leaves on rsp_if, with run_last on the final byte that a
// command causes and truncated on trailer bytes of a frame that lost data.
// csr_wr_data is written into the frame limit when csr_wr_en is high; write
// it only while the unit is idle.
// The first byte of a command passes the job queue, then the output register.
// It emits one byte per cycle while the receiver takes them, so a data byte
// yields one or two bytes and a header four to six; the job queue lets the
// front end take a command every cycle while not full, as the back end works
// off earlier ones. Commands that produce no bytes only update the frame state.
// Reset clears the frame state, empties the queue and sets the limit to 1024.
// When the receiver stalls, the output byte holds, the back end waits, and
// req_if.ready drops once the job queue is full.
// ----------------------------------------------------------------------------
`default_nettype none

module dle_frame_stuffer_unit #(
   parameter int unsigned QUEUE_DEPTH = dfs_pkg::QUEUE_DEPTH
) (
   input  wire logic        clock,
   input  wire logic        reset,
   dfs_req_if.sink          req_if,
   dfs_rsp_if.source        rsp_if,
   input  wire logic        csr_wr_en,
   input  wire logic [15:0] csr_wr_data
);

   logic             push;
   dfs_pkg::job_type push_job;
   logic             pop;
   logic             queue_full;
   logic             head_valid;
   dfs_pkg::job_type head_job;

   dfs_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_if),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .queue_full  (queue_full),
      .push        (push),
      .push_job    (push_job)
   );

   dfs_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .pop        (pop),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   dfs_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_job   (head_job),
      .pop        (pop),
      .rsp_if     (rsp_if)
   );

`ifndef SYNTHESIS
   // Only trailer bytes may carry the truncated flag.
   assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.truncated |->
         (rsp_if.out_byte == dfs_pkg::B_DLE) || (rsp_if.out_byte == dfs_pkg::B_ETX))
      else $error("truncated flag on a non-trailer byte");

   // A truncated trailer ends on ETX, never on its DLE.
   assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.truncated |->
         (rsp_if.run_last == (rsp_if.out_byte == dfs_pkg::B_ETX)))
      else $error("truncated trailer with wrong run_last");

   // The output register is empty right after reset.
   assert property (@(posedge clock) reset |=> !rsp_if.valid)
      else $error("response valid right after reset");

   // The queue is never popped while empty.
   assert property (@(posedge clock) disable iff (reset) pop |-> head_valid)
      else $error("job queue popped while empty");
`endif

endmodule

`default_nettype wire
